/* hw/rtl/bnmv_pkg.sv */
// Package for the banked nibble bitmap VRAM: bus command codes, field widths
// and the result record passed from the merge logic to the output register.
// No dependencies.
package bnmv_pkg;

  typedef enum logic [2:0] {
    CMD_VRAM_WR = 3'd0,
    CMD_VRAM_RD = 3'd1,
    CMD_VREG_WR = 3'd2,
    CMD_VREG_RD = 3'd3,
    CMD_PEN_WR  = 3'd4
  } cmd_t;

  localparam int CMD_W     = 3;
  localparam int OFFSET_W  = 13;
  localparam int BYTE_W    = 8;
  localparam int PIX_IDX_W = 18;
  localparam int PIX_VAL_W = 11;
  localparam int BANK_SEL_W = 5;

  localparam logic [3:0] NIBBLE_CLEAR = 4'hf;

  typedef struct packed {
    logic [BYTE_W-1:0]    read_byte;
    logic                 target_layer;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic                 low_pixel_valid;
    logic [PIX_VAL_W-1:0] low_pixel_value;
    logic                 high_pixel_valid;
    logic [PIX_VAL_W-1:0] high_pixel_value;
  } result_t;

endpackage

/* hw/rtl/bnmv_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module bnmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bnmv_addr.sv */
// Store address generation: wraps the bank select and the byte offset and
// forms bank * BANK_BYTES + offset. Uses bnmv_pkg for field widths.
module bnmv_addr #(
  parameter int BANK_BYTES = 8192,
  parameter int BANK_COUNT = 32,
  localparam int ADDR_W = $clog2(BANK_BYTES * BANK_COUNT)
) (
  input  logic [bnmv_pkg::BANK_SEL_W-1:0] bank_sel,
  input  logic [bnmv_pkg::OFFSET_W-1:0]   offset,
  output logic [ADDR_W-1:0]               addr
);

  localparam int BKW     = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int SEL_N   = 2 ** bnmv_pkg::BANK_SEL_W;
  localparam int REM_W   = bnmv_pkg::OFFSET_W + 8;
  // offset < 8192 and BANK_BYTES >= 256, so the quotient fits in five bits
  localparam int Q_STEPS = 5;

  logic [BKW-1:0]   bank_map [SEL_N];
  logic [REM_W-1:0] rem [Q_STEPS+1];

  for (genvar g = 0; g < SEL_N; g++) begin : g_bank_map
    assign bank_map[g] = BKW'(g % BANK_COUNT);
  end

  assign rem[Q_STEPS] = REM_W'(offset);

  // restoring reduction, one quotient bit a step
  for (genvar k = Q_STEPS - 1; k >= 0; k--) begin : g_mod
    assign rem[k] = (rem[k+1] >= (REM_W'(BANK_BYTES) << k))
                  ? rem[k+1] - (REM_W'(BANK_BYTES) << k)
                  : rem[k+1];
  end

  assign addr = ADDR_W'(bank_map[bank_sel]) * ADDR_W'(BANK_BYTES) + ADDR_W'(rem[0]);

endmodule

/* hw/rtl/bnmv_merge.sv */
// Nibble merge and result formation for one bus transfer: transparent nibble
// handling, byte write-back value and pixel fields. Uses bnmv_pkg.
module bnmv_merge #(
  parameter int BANK_BYTES = 8192
) (
  input  logic [bnmv_pkg::CMD_W-1:0]    cmd,
  input  logic [bnmv_pkg::OFFSET_W-1:0] offset,
  input  logic [bnmv_pkg::BYTE_W-1:0]   data,
  input  logic [bnmv_pkg::BYTE_W-1:0]   old_byte,
  input  logic [bnmv_pkg::BYTE_W-1:0]   video,
  input  logic [bnmv_pkg::BYTE_W-1:0]   pen,
  output logic [bnmv_pkg::BYTE_W-1:0]   new_byte,
  output bnmv_pkg::result_t             result
);

  logic        fg;
  logic        opaque;
  logic        lo_clear;
  logic        hi_clear;
  logic [31:0] idx_sum;

  assign fg       = video[4];
  assign opaque   = fg | pen[7];
  assign lo_clear = !opaque && (data[3:0] == bnmv_pkg::NIBBLE_CLEAR);
  assign hi_clear = !opaque && (data[7:4] == bnmv_pkg::NIBBLE_CLEAR);

  // keep the stored nibble where the written one is transparent
  assign new_byte = {hi_clear ? old_byte[7:4] : data[7:4],
                     lo_clear ? old_byte[3:0] : data[3:0]};

  assign idx_sum = 32'(offset) + 32'(video[3:0]) * 32'(BANK_BYTES);

  always_comb begin
    result = '0;
    unique case (cmd)
      bnmv_pkg::CMD_VRAM_WR: begin
        result.target_layer     = fg;
        result.pixel_index      = {idx_sum[bnmv_pkg::PIX_IDX_W-2:0], 1'b0};
        result.low_pixel_valid  = !lo_clear;
        result.high_pixel_valid = !hi_clear;
        if (!lo_clear) begin
          result.low_pixel_value = {pen[6:0], new_byte[3:0]};
        end
        if (!hi_clear) begin
          result.high_pixel_value = {pen[6:0], new_byte[7:4]};
        end
      end
      bnmv_pkg::CMD_VRAM_RD: result.read_byte = old_byte;
      bnmv_pkg::CMD_VREG_RD: result.read_byte = video;
      default:               result = '0;
    endcase
  end

endmodule

/* hw/rtl/banked_nibble_masked_bitmap_vram_top.sv */
// Top level of the banked 4-bit-per-pixel bitmap VRAM.
// Depends on bnmv_pkg, bnmv_ram, bnmv_addr and bnmv_merge.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one bus access per transfer:
//   a VRAM byte write or read, a video register write or read, or a pen write.
//   Every accepted access returns exactly one result on the output channel
//   (out_valid / out_stall): the read byte, or for a VRAM write the layer,
//   framebuffer index and the two pixels it emits.
//   An access passes the merge stage and then the output register. One access
//   can be taken per cycle while the output is not stalled; the store is read
//   once at the transfer edge and written back as the access leaves the merge
//   stage; the written byte is forwarded to a same-address access right after.
//   After reset the store is swept to zero one byte per cycle over all
//   BANK_BYTES * BANK_COUNT bytes (262144 at the defaults); in_stall stays
//   high until the sweep ends. Video and pen registers reset to zero.
//   When the receiver stalls, the finished result waits in the output
//   register, one more access is taken and held in the merge stage, and then
//   in_stall rises until the output drains.
module banked_nibble_masked_bitmap_vram_top #(
  parameter int BANK_BYTES = 8192,
  parameter int BANK_COUNT = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bnmv_pkg::CMD_W-1:0]         in_command,
  input  logic [bnmv_pkg::OFFSET_W-1:0]      in_byte_offset,
  input  logic [bnmv_pkg::BYTE_W-1:0]        in_write_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bnmv_pkg::BYTE_W-1:0]        out_read_byte,
  output logic                               out_target_layer,
  output logic [bnmv_pkg::PIX_IDX_W-1:0]     out_pixel_index,
  output logic                               out_low_pixel_valid,
  output logic [bnmv_pkg::PIX_VAL_W-1:0]     out_low_pixel_value,
  output logic                               out_high_pixel_valid,
  output logic [bnmv_pkg::PIX_VAL_W-1:0]     out_high_pixel_value
);

  localparam int DEPTH  = BANK_BYTES * BANK_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                            clr_active_r;
  logic [ADDR_W-1:0]               clr_addr_r;

  logic                            s1_valid_r;
  logic [bnmv_pkg::CMD_W-1:0]      s1_cmd_r;
  logic [bnmv_pkg::OFFSET_W-1:0]   s1_off_r;
  logic [bnmv_pkg::BYTE_W-1:0]     s1_data_r;
  logic [ADDR_W-1:0]               s1_addr_r;
  logic                            fwd_r;
  logic [bnmv_pkg::BYTE_W-1:0]     fwd_data_r;

  logic [bnmv_pkg::BYTE_W-1:0]     video_r;
  logic [bnmv_pkg::BYTE_W-1:0]     pen_r;

  logic                            out_valid_r;
  bnmv_pkg::result_t               out_res_r;

  logic                            in_acc;
  logic                            s1_go;
  logic                            s1_retire;
  logic                            s1_is_wr;
  logic [bnmv_pkg::BYTE_W-1:0]     video_eff;
  logic [ADDR_W-1:0]               rd_addr;
  logic [bnmv_pkg::BYTE_W-1:0]     ram_rdata;
  logic [bnmv_pkg::BYTE_W-1:0]     old_byte;
  logic [bnmv_pkg::BYTE_W-1:0]     new_byte;
  bnmv_pkg::result_t               s1_res;
  logic                            ram_we;
  logic [ADDR_W-1:0]               ram_waddr;
  logic [bnmv_pkg::BYTE_W-1:0]     ram_wdata;

  assign s1_go     = !out_valid_r || !out_stall;
  assign s1_retire = s1_valid_r && s1_go;
  assign s1_is_wr  = (s1_cmd_r == bnmv_pkg::CMD_VRAM_WR);
  assign in_stall  = clr_active_r || (s1_valid_r && !s1_go);
  assign in_acc    = in_valid && !in_stall;

  // the retiring access updates the video register at this same edge
  assign video_eff = (s1_valid_r && s1_cmd_r == bnmv_pkg::CMD_VREG_WR) ? s1_data_r : video_r;

  bnmv_addr #(
    .BANK_BYTES (BANK_BYTES),
    .BANK_COUNT (BANK_COUNT)
  ) u_addr (
    .bank_sel (video_eff[bnmv_pkg::BANK_SEL_W-1:0]),
    .offset   (in_byte_offset),
    .addr     (rd_addr)
  );

  assign ram_we    = clr_active_r || (s1_retire && s1_is_wr);
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_active_r ? '0 : new_byte;

  bnmv_ram #(
    .WIDTH (bnmv_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign old_byte = fwd_r ? fwd_data_r : ram_rdata;

  bnmv_merge #(
    .BANK_BYTES (BANK_BYTES)
  ) u_merge (
    .cmd      (s1_cmd_r),
    .offset   (s1_off_r),
    .data     (s1_data_r),
    .old_byte (old_byte),
    .video    (video_r),
    .pen      (pen_r),
    .new_byte (new_byte),
    .result   (s1_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      video_r      <= '0;
      pen_r        <= '0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_retire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_retire) begin
        out_valid_r <= 1'b1;
        if (s1_cmd_r == bnmv_pkg::CMD_VREG_WR) begin
          video_r <= s1_data_r;
        end
        if (s1_cmd_r == bnmv_pkg::CMD_PEN_WR) begin
          pen_r <= s1_data_r;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_command;
      s1_off_r   <= in_byte_offset;
      s1_data_r  <= in_write_byte;
      s1_addr_r  <= rd_addr;
      // bypass the RAM when the retiring write hits the address just read
      fwd_r      <= s1_retire && s1_is_wr && (s1_addr_r == rd_addr);
      fwd_data_r <= new_byte;
    end
    if (s1_retire) begin
      out_res_r <= s1_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_byte        = out_res_r.read_byte;
  assign out_target_layer     = out_res_r.target_layer;
  assign out_pixel_index      = out_res_r.pixel_index;
  assign out_low_pixel_valid  = out_res_r.low_pixel_valid;
  assign out_low_pixel_value  = out_res_r.low_pixel_value;
  assign out_high_pixel_valid = out_res_r.high_pixel_valid;
  assign out_high_pixel_value = out_res_r.high_pixel_value;

`ifndef SYNTHESIS
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_valid_r && !out_valid_r)
    else $error("access in flight during store clear");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_addr_r) && $stable(s1_cmd_r))
    else $error("merge stage lost its access while blocked");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_retire |=> out_valid_r)
    else $error("retired access produced no result");

  a_fwd_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_retire && s1_is_wr && (s1_addr_r == rd_addr) |=> fwd_r)
    else $error("write-read hazard not forwarded");
`endif

endmodule
